// ===== hdl/sef_pkg.sv =====
// Shared constants, types and stage map for the Schwarzschild EF tensor point kernel.
// Used by every module under hdl/ except sef_mul; depends on nothing.
package sef_pkg;

  localparam int COORD_FRAC_BITS = 24;
  localparam int SH = 2 * COORD_FRAC_BITS + 1;
  localparam int KR_SHL = (SH >= 32) ? SH - 32 : 0;
  localparam int KR_SHR = (SH >= 32) ? 0 : 32 - SH;

  localparam int POS_W  = 32;
  localparam int COMP_W = 48;
  localparam int MASS_W = 31;
  localparam int TOL_W  = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int N_COMP = 6;

  localparam logic [MASS_W-1:0] MASS_RESET = 31'd16777216;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 25'd16;

  localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] OUT_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] OUT_NEG_MAG = 64'h0000_8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS     = 2'd0,
    REG_AXIS_TOL = 2'd1
  } cfg_reg_t;

  // Index pairs of the six components: xx xy xz yy yz zz
  localparam logic [1:0] PAIR_A [N_COMP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [N_COMP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  // Unit latencies in cycles
  localparam int DIV_LAT  = 64;
  localparam int SQRT_LAT = 64;
  localparam int MUL_LAT  = 2;

  // Stage map: the stage index at which each value sits in a register
  localparam int S_MAG  = 1;
  localparam int S_PROD = 2;
  localparam int S_R2   = 3;
  localparam int S_AX1  = 4;
  localparam int S_AX2  = 5;
  localparam int S_SR   = S_R2 + SQRT_LAT;
  localparam int S_DIV1 = S_SR + DIV_LAT;
  localparam int S_T    = S_DIV1 + SQRT_LAT;
  localparam int S_MUL1 = S_T + MUL_LAT;
  localparam int S_DIV2 = S_MUL1 + DIV_LAT;
  localparam int S_PDQ  = S_DIV2 + 1;
  localparam int S_MUL2 = S_PDQ + MUL_LAT;

  typedef struct packed {
    logic              vld;
    logic              op;
    logic              zero;
    logic [N_COMP-1:0] sneg;
  } tag_t;

endpackage

// ===== hdl/sef_div.sv =====
// Pipelined restoring divider: 128-bit dividend, 65-bit divisor, 64-bit saturated quotient.
// One quotient bit per stage; depends on sef_pkg.
module sef_div (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] num,
  input  logic [64:0]  den,
  output logic [63:0]  quo
);

  logic [64:0] rem_r [sef_pkg::DIV_LAT];
  logic [63:0] low_r [sef_pkg::DIV_LAT];
  logic [64:0] den_r [sef_pkg::DIV_LAT];
  logic [63:0] q_r   [sef_pkg::DIV_LAT];
  logic        sat_r [sef_pkg::DIV_LAT];

  for (genvar j = 0; j < sef_pkg::DIV_LAT; j++) begin : g_stage
    logic [64:0] rem_in;
    logic [63:0] low_in;
    logic [64:0] den_in;
    logic [63:0] q_in;
    logic        sat_in;
    logic [65:0] cand;
    logic [65:0] diff;
    logic        take;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, num[127:64]};
      assign low_in = num[63:0];
      assign den_in = den;
      assign q_in   = '0;
      // quotient does not fit in 64 bits
      assign sat_in = ({1'b0, num[127:64]} >= den);
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign low_in = low_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign cand = {rem_in, low_in[63]};
    assign diff = cand - {1'b0, den_in};
    assign take = (cand >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? diff[64:0] : cand[64:0];
        low_r[j] <= {low_in[62:0], 1'b0};
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[62:0], take};
        sat_r[j] <= sat_in;
      end
    end
  end

  assign quo = sat_r[sef_pkg::DIV_LAT-1] ? '1 : q_r[sef_pkg::DIV_LAT-1];

endmodule

// ===== hdl/sef_sqrt.sv =====
// Pipelined digit-by-digit integer square root: 128-bit radicand, 64-bit floor root.
// One root bit per stage; depends on sef_pkg.
module sef_sqrt (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] rad,
  output logic [63:0]  root
);

  logic [65:0]  rem_r  [sef_pkg::SQRT_LAT];
  logic [63:0]  root_r [sef_pkg::SQRT_LAT];
  logic [127:0] rad_r  [sef_pkg::SQRT_LAT];

  for (genvar j = 0; j < sef_pkg::SQRT_LAT; j++) begin : g_stage
    logic [65:0]  rem_in;
    logic [63:0]  root_in;
    logic [127:0] rad_in;
    logic [67:0]  cand;
    logic [67:0]  trial;
    logic [67:0]  diff;
    logic         take;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    assign cand  = {rem_in, rad_in[127:126]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cand - trial;
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= take ? diff[65:0] : cand[65:0];
        root_r[j] <= {root_in[62:0], take};
        rad_r[j]  <= {rad_in[125:0], 2'b00};
      end
    end
  end

  assign root = root_r[sef_pkg::SQRT_LAT-1];

endmodule

// ===== hdl/sef_mul.sv =====
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Stage one registers the partials, stage two registers the sum; depends on nothing.
module sef_mul (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic [127:0]  p
);

  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a[31:0]  * b[31:0];
      p01_r <= a[31:0]  * b[63:32];
      p10_r <= a[63:32] * b[31:0];
      p11_r <= a[63:32] * b[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
           + {p11_r, 64'b0};
    end
  end

  assign p = p_r;

  // every stage advances together under the shared enable
endmodule

// ===== hdl/schwarzschild_ef_tensor_point.sv =====
// Top level of the Schwarzschild EF tensor point kernel: handshakes, stage map, projection.
// Depends on sef_pkg, sef_sqrt, sef_div and sef_mul.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | sink      | in_valid/in_ready   | in_opcode, in_pos_x, in_pos_y, in_pos_z
//   out     | source    | out_valid/out_ready | out_comp_xx .. out_comp_zz, out_fault
//   cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction enters per cycle while the pipeline is not held; its result leaves from the
// output register. The depth is set by the chain sqrt(r2) -> divide -> sqrt(t) -> divide,
// each a 64-stage unit retiring one bit per stage, plus the multiply and projection stages.
// Reset (rst_n low at a clock edge) clears every valid bit and reloads mass and axis
// tolerance with their defaults. A full output register that is not taken holds the whole
// pipeline; nothing is dropped or repeated. cfg_ready is always high.
module schwarzschild_ef_tensor_point (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [sef_pkg::POS_W-1:0]      in_pos_x,
  input  logic [sef_pkg::POS_W-1:0]      in_pos_y,
  input  logic [sef_pkg::POS_W-1:0]      in_pos_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_xx,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_xy,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_xz,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_yy,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_yz,
  output logic [sef_pkg::COMP_W-1:0]     out_comp_zz,
  output logic                           out_fault,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sef_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int S_PROD = sef_pkg::S_PROD;
  localparam int S_R2   = sef_pkg::S_R2;
  localparam int S_AX2  = sef_pkg::S_AX2;
  localparam int S_SR   = sef_pkg::S_SR;
  localparam int S_DIV1 = sef_pkg::S_DIV1;
  localparam int S_T    = sef_pkg::S_T;
  localparam int S_MUL1 = sef_pkg::S_MUL1;
  localparam int S_DIV2 = sef_pkg::S_DIV2;
  localparam int S_PDQ  = sef_pkg::S_PDQ;
  localparam int S_MUL2 = sef_pkg::S_MUL2;
  localparam int NC     = sef_pkg::N_COMP;

  // Combine the signed first term with the non-negative diagonal term and clamp to 48 bits.
  function automatic logic [47:0] pack_out(input logic neg1, input logic [63:0] m1,
                                           input logic [63:0] m2);
    logic [64:0] sum;
    logic        neg;
    logic [63:0] mag;
    sum = {1'b0, m1} + {1'b0, m2};
    if (!neg1) begin
      neg = 1'b0;
      mag = sum[64] ? '1 : sum[63:0];
    end else if (m2 >= m1) begin
      neg = 1'b0;
      mag = m2 - m1;
    end else begin
      neg = 1'b1;
      mag = m1 - m2;
    end
    if (!neg) begin
      return (mag > sef_pkg::OUT_POS_MAX) ? sef_pkg::OUT_POS_MAX[47:0] : mag[47:0];
    end
    if (mag > sef_pkg::OUT_NEG_MAG) begin
      mag = sef_pkg::OUT_NEG_MAG;
    end
    return 48'd0 - mag[47:0];
  endfunction

  // ---------------------------------------------------------------- control
  logic en;
  logic out_valid_r;

  // Advance every stage unless a finished result is waiting in the output register.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- configuration
  logic [sef_pkg::MASS_W-1:0] mass_r;
  logic [sef_pkg::TOL_W-1:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= sef_pkg::MASS_RESET;
      tol_r  <= sef_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      // writes to unknown indexes fall through
      if (cfg_index == sef_pkg::REG_MASS) begin
        mass_r <= cfg_data;
      end else if (cfg_index == sef_pkg::REG_AXIS_TOL) begin
        tol_r <= cfg_data[sef_pkg::TOL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: magnitudes
  logic [31:0] pos [3];
  logic [31:0] mag_r [3];
  logic        neg_r [3];
  logic        v1_r, op1_r;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= pos[i][31];
        mag_r[i] <= pos[i][31] ? (~pos[i] + 32'd1) : pos[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_opcode;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic [NC-1:0][63:0] prod_r [S_PROD:S_MUL1];
  logic [NC-1:0]       sneg2_r;
  logic                v2_r, op2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[S_PROD][k] <= mag_r[sef_pkg::PAIR_A[k]] * mag_r[sef_pkg::PAIR_B[k]];
        // a zero product carries no sign
        sneg2_r[k] <= (neg_r[sef_pkg::PAIR_A[k]] ^ neg_r[sef_pkg::PAIR_B[k]])
                    && (mag_r[sef_pkg::PAIR_A[k]] != 32'd0)
                    && (mag_r[sef_pkg::PAIR_B[k]] != 32'd0);
      end
    end
  end

  for (genvar i = S_PROD + 1; i <= S_MUL1; i++) begin : g_prod_dly
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[i] <= prod_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: r2, s2
  sef_pkg::tag_t tag_r [S_R2:S_MUL2];
  logic [63:0]   r2_r  [S_R2:S_MUL1];
  logic [63:0]   s2_c, r2_c;
  logic [63:0]   s2_r;

  assign s2_c = prod_r[S_PROD][0] + prod_r[S_PROD][3];
  assign r2_c = s2_c + prod_r[S_PROD][5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[S_R2].vld <= 1'b0;
    end else if (en) begin
      tag_r[S_R2].vld  <= v2_r;
      tag_r[S_R2].op   <= op2_r;
      tag_r[S_R2].zero <= (r2_c == 64'd0);
      tag_r[S_R2].sneg <= sneg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r[S_R2] <= r2_c;
      s2_r       <= s2_c;
    end
  end

  for (genvar i = S_R2 + 1; i <= S_MUL2; i++) begin : g_tag_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i].vld <= 1'b0;
      end else if (en) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  for (genvar i = S_R2 + 1; i <= S_MUL1; i++) begin : g_r2_dly
    always_ff @(posedge clk) begin
      if (en) begin
        r2_r[i] <= r2_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 4-5: axis test
  // Near the z axis when s2 * 2^F <= tol * r2; the product is split into two halves.
  logic [56:0] axlo_r, axhi_r;
  logic [63:0] s2a_r;
  logic [95:0] ax_lhs, ax_rhs;
  logic        axis_r [S_AX2:S_PDQ];

  always_ff @(posedge clk) begin
    if (en) begin
      axlo_r <= tol_r * r2_r[S_R2][31:0];
      axhi_r <= tol_r * r2_r[S_R2][63:32];
      s2a_r  <= s2_r;
    end
  end

  assign ax_lhs = {32'b0, s2a_r} << sef_pkg::COORD_FRAC_BITS;
  assign ax_rhs = {7'b0, axhi_r, 32'b0} + {39'b0, axlo_r};

  always_ff @(posedge clk) begin
    if (en) begin
      axis_r[S_AX2] <= (ax_lhs <= ax_rhs);
    end
  end

  for (genvar i = S_AX2 + 1; i <= S_PDQ; i++) begin : g_axis_dly
    always_ff @(posedge clk) begin
      if (en) begin
        axis_r[i] <= axis_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- SR = sqrt(r2 * 2^64)
  logic [63:0] sr;

  sef_sqrt u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .rad  ({r2_r[S_R2], 64'b0}),
    .root (sr)
  );

  // ---------------------------------------------------------------- u = m/r, t^2 quotient
  logic [63:0] u_q, tq;
  logic [64:0] t_den;
  logic [63:0] u_r [S_DIV1+1:S_DIV2];

  assign t_den = {1'b0, sr} + {1'b0, mass_r, 33'b0};

  sef_div u_div_u (
    .clk (clk),
    .en  (en),
    .num ({33'b0, mass_r, 64'b0}),
    .den ({1'b0, sr}),
    .quo (u_q)
  );

  // With zero mass the quotient is exactly 2^64; that case bypasses this path below.
  sef_div u_div_t (
    .clk (clk),
    .en  (en),
    .num ({sr, 64'b0}),
    .den (t_den),
    .quo (tq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[S_DIV1+1] <= u_q;
    end
  end

  for (genvar i = S_DIV1 + 2; i <= S_DIV2; i++) begin : g_u_dly
    always_ff @(posedge clk) begin
      if (en) begin
        u_r[i] <= u_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- t = sqrt(tq)
  logic [63:0]  t_root;
  logic [32:0]  t_c;
  logic [32:0]  t_r [S_T+1:S_MUL1];
  logic [127:0] kp;

  sef_sqrt u_sqrt_t (
    .clk  (clk),
    .en   (en),
    .rad  ({64'b0, tq}),
    .root (t_root)
  );

  assign t_c = (mass_r == '0) ? 33'h1_0000_0000 : {1'b0, t_root[31:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[S_T+1] <= t_c;
    end
  end

  for (genvar i = S_T + 2; i <= S_MUL1; i++) begin : g_t_dly
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[i] <= t_r[i-1];
      end
    end
  end

  // (1 + m/r) * t in Q.64
  sef_mul u_mul_k (
    .clk (clk),
    .en  (en),
    .a   (sef_pkg::ONE_Q32 + u_r[S_T]),
    .b   ({31'b0, t_c}),
    .p   (kp)
  );

  // ---------------------------------------------------------------- Q_K, |K_rr|, n_i n_j
  logic [63:0] qk_q, kr_q;
  logic [63:0] nn_q [NC];

  sef_div u_div_qk (
    .clk (clk),
    .en  (en),
    .num ({95'b0, t_r[S_MUL1]} << sef_pkg::SH),
    .den ({1'b0, r2_r[S_MUL1]}),
    .quo (qk_q)
  );

  sef_div u_div_kr (
    .clk (clk),
    .en  (en),
    .num ((kp << sef_pkg::KR_SHL) >> sef_pkg::KR_SHR),
    .den ({1'b0, r2_r[S_MUL1]}),
    .quo (kr_q)
  );

  for (genvar k = 0; k < NC; k++) begin : g_nn
    sef_div u_div_nn (
      .clk (clk),
      .en  (en),
      .num ({64'b0, prod_r[S_MUL1][k]} << 63),
      .den ({1'b0, r2_r[S_MUL1]}),
      .quo (nn_q[k])
    );
  end

  // ---------------------------------------------------------------- spherical scalars
  // p: radial term, d: radial minus angular, q: angular term (all magnitudes).
  logic [64:0] met_p_sum, cur_d_sum;
  logic [63:0] p_nxt, d_nxt, q_nxt;
  logic [63:0] p_r, d_r;
  logic [63:0] q_r [S_PDQ:S_MUL2];
  logic [63:0] nn_r [NC];

  assign met_p_sum = {1'b0, sef_pkg::ONE_Q32} + {u_r[S_DIV2], 1'b0};
  assign cur_d_sum = {1'b0, kr_q} + {1'b0, qk_q};

  always_comb begin
    if (tag_r[S_DIV2].op) begin
      p_nxt = kr_q;
      d_nxt = cur_d_sum[64] ? '1 : cur_d_sum[63:0];
      q_nxt = qk_q;
    end else begin
      p_nxt = met_p_sum[64] ? '1 : met_p_sum[63:0];
      d_nxt = {u_r[S_DIV2][62:0], 1'b0};
      q_nxt = sef_pkg::ONE_Q32;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r        <= p_nxt;
      d_r        <= d_nxt;
      q_r[S_PDQ] <= q_nxt;
    end
  end

  for (genvar i = S_PDQ + 1; i <= S_MUL2; i++) begin : g_q_dly
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- projection
  logic [127:0] proj [NC];
  logic [47:0]  enc  [NC];
  logic [47:0]  comp_r [NC];
  logic         fault_r;

  for (genvar k = 0; k < NC; k++) begin : g_proj
    logic [63:0] sc;
    logic [63:0] diag;

    always_ff @(posedge clk) begin
      if (en) begin
        nn_r[k] <= nn_q[k];
      end
    end

    // xx, xy, yy take the axis-limit form near the z axis
    assign sc = (axis_r[S_PDQ] && (sef_pkg::PAIR_B[k] < 2'd2)) ? p_r : d_r;

    sef_mul u_mul_p (
      .clk (clk),
      .en  (en),
      .a   (nn_r[k]),
      .b   (sc),
      .p   (proj[k])
    );

    assign diag   = (sef_pkg::PAIR_A[k] == sef_pkg::PAIR_B[k]) ? q_r[S_MUL2] : 64'd0;
    assign enc[k] = pack_out(tag_r[S_MUL2].sneg[k] ^ tag_r[S_MUL2].op, proj[k][126:63],
                             diag);

    always_ff @(posedge clk) begin
      if (en) begin
        comp_r[k] <= tag_r[S_MUL2].zero ? 48'd0 : enc[k];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_r[S_MUL2].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault_r <= tag_r[S_MUL2].zero;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_comp_xx = comp_r[0];
  assign out_comp_xy = comp_r[1];
  assign out_comp_xz = comp_r[2];
  assign out_comp_yy = comp_r[3];
  assign out_comp_yz = comp_r[4];
  assign out_comp_zz = comp_r[5];
  assign out_fault   = fault_r;

endmodule

// ===== verif/sef_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Schwarzschild EF tensor point kernel: predicts each tensor from the
// accepted position and the live mass and tolerance, then compares. Depends on sef_pkg.
module sef_checker
  import sef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic [POS_W-1:0]      in_pos_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COMP_W-1:0]     out_comp_xx,
  input  logic [COMP_W-1:0]     out_comp_xy,
  input  logic [COMP_W-1:0]     out_comp_xz,
  input  logic [COMP_W-1:0]     out_comp_yy,
  input  logic [COMP_W-1:0]     out_comp_yz,
  input  logic [COMP_W-1:0]     out_comp_zz,
  input  logic                  out_fault,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic [COMP_W-1:0] comp [N_COMP];
    logic              fault;
  } tensor_t;

  localparam logic [63:0] ALL_ONES = '1;

  logic [63:0] mass_q;
  logic [63:0] tol_q;
  tensor_t     tensor_q [$];

  function automatic logic [63:0] root128(input logic [127:0] n);
    logic [127:0] res, b, t;
    res = '0;
    b   = 128'h1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      t = res + b;
      if (n >= t) begin
        n   = n - t;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [63:0] clip64(input logic [127:0] a);
    return (a[127:64] != 0) ? ALL_ONES : a[63:0];
  endfunction

  function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  // Signed sum of a projected term and the diagonal term, clipped to 48 bits.
  function automatic logic [COMP_W-1:0] pack48(input logic neg1, input logic [63:0] m1,
                                               input logic [63:0] m2);
    logic        neg;
    logic [63:0] mag;
    if (!neg1) begin
      neg = 1'b0;
      mag = add_clip(m1, m2);
    end else if (m2 >= m1) begin
      neg = 1'b0;
      mag = m2 - m1;
    end else begin
      neg = 1'b1;
      mag = m1 - m2;
    end
    if (!neg) return (mag > OUT_POS_MAX) ? OUT_POS_MAX[COMP_W-1:0] : mag[COMP_W-1:0];
    if (mag > OUT_NEG_MAG) mag = OUT_NEG_MAG;
    mag = 64'd0 - mag;
    return mag[COMP_W-1:0];
  endfunction

  function automatic tensor_t tensor_at(input logic op, input logic [31:0] px,
                                        input logic [31:0] py, input logic [31:0] pz);
    tensor_t      r;
    logic [31:0]  v [3];
    logic [63:0]  mag [3];
    logic         neg [3];
    logic [63:0]  r2, s2, sr, u, t, qk, kr, p, d, q, prod, nn, sc, am;
    logic [127:0] num, den, wsc;
    logic         on_axis, pneg, dneg, sneg, scneg, use_axis;
    v[0] = px;
    v[1] = py;
    v[2] = pz;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, v[i]}) : {32'd0, v[i]};
    end
    for (int k = 0; k < N_COMP; k++) r.comp[k] = '0;
    r.fault = 1'b0;
    s2 = mag[0] * mag[0] + mag[1] * mag[1];
    r2 = s2 + mag[2] * mag[2];
    if (r2 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    on_axis = ({64'd0, s2} << COORD_FRAC_BITS) <= ({64'd0, tol_q} * {64'd0, r2});
    sr = root128({r2, 64'd0});
    u  = clip64({mass_q, 64'd0} / {64'd0, sr});
    if (!op) begin
      p    = add_clip(ONE_Q32, u + u);
      d    = u + u;
      q    = ONE_Q32;
      pneg = 1'b0;
      dneg = 1'b0;
    end else begin
      den  = {64'd0, sr} + ({64'd0, mass_q} << 33);
      t    = root128({sr, 64'd0} / den);
      qk   = clip64(({64'd0, t} << SH) / {64'd0, r2});
      num  = {64'd0, ONE_Q32 + u} * {64'd0, t};
      if (SH >= 32) begin
        num = num << KR_SHL;
        den = {64'd0, r2};
      end else begin
        den = {64'd0, r2} << KR_SHR;
      end
      kr   = clip64(num / den);
      p    = kr;
      d    = add_clip(kr, qk);
      q    = qk;
      pneg = 1'b1;
      dneg = 1'b1;
    end
    for (int k = 0; k < N_COMP; k++) begin
      prod     = mag[PAIR_A[k]] * mag[PAIR_B[k]];
      sneg     = (neg[PAIR_A[k]] != neg[PAIR_B[k]]) && prod != 0;
      nn       = clip64(({64'd0, prod} << 63) / {64'd0, r2});
      use_axis = on_axis && PAIR_B[k] < 2;
      sc       = use_axis ? p : d;
      scneg    = use_axis ? pneg : dneg;
      wsc      = ({64'd0, nn} * {64'd0, sc}) >> 63;
      am       = wsc[63:0];
      r.comp[k] = pack48(sneg != scneg, am, (PAIR_A[k] == PAIR_B[k]) ? q : 64'd0);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tensor_t          exp_t;
    logic [COMP_W-1:0] got [N_COMP];
    int               errs;
    errs = 0;
    if (!rst_n) begin
      mass_q     <= {33'd0, MASS_RESET};
      tol_q      <= {39'd0, TOL_RESET};
      fail_count <= 0;
      pending    <= 0;
      tensor_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS:     mass_q <= {33'd0, cfg_data[MASS_W-1:0]};
          REG_AXIS_TOL: tol_q  <= {39'd0, cfg_data[TOL_W-1:0]};
          default:      ;  // drop writes to unmapped indexes
        endcase
      end
      if (in_valid && in_ready)
        tensor_q.push_back(tensor_at(in_opcode, in_pos_x, in_pos_y, in_pos_z));
      if (out_valid && out_ready) begin
        got = '{out_comp_xx, out_comp_xy, out_comp_xz, out_comp_yy, out_comp_yz, out_comp_zz};
        if (tensor_q.size() == 0) begin
          $display("%0t: unexpected result transaction", $time);
          errs = errs + 1;
        end else begin
          exp_t = tensor_q.pop_front();
          for (int k = 0; k < N_COMP; k++)
            if (got[k] !== exp_t.comp[k]) begin
              $display("%0t: comp %0d expected %h actual %h", $time, k, exp_t.comp[k], got[k]);
              errs = errs + 1;
            end
          if (out_fault !== exp_t.fault) begin
            $display("%0t: fault expected %b actual %b", $time, exp_t.fault, out_fault);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= tensor_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the tensor point testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on sef_pkg, the schwarzschild_ef_tensor_point block and sef_checker.
module testbench;
  import sef_pkg::*;

  // Indexes past the register map; writes there must leave the registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [CFG_DATA_W-1:0] ONE_Q24 = 31'd16777216;
  localparam logic [CFG_DATA_W-1:0] DATA_MAX = '1;
  localparam logic OP_METRIC    = 1'b0;
  localparam logic OP_CURVATURE = 1'b1;
  // Drain time after the last result, with margin over the pipeline depth.
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 258;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_opcode;
  logic [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, out_ready, out_fault;
  logic [COMP_W-1:0] out_comp_xx, out_comp_xy, out_comp_xz;
  logic [COMP_W-1:0] out_comp_yy, out_comp_yz, out_comp_zz;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;

  int in_idle_pct;
  int out_idle_pct;
  int out_hold;        // remaining cycles of a forced output stall
  int quiet_cycles;

  schwarzschild_ef_tensor_point i_dut (.*);

  sef_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: drop ready at random, or hold it low for a forced stretch.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog: count cycles where no transaction moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one position; hold it until the block takes it.
  task automatic send_point(input logic op, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_opcode = op;
    in_pos_x  = x;
    in_pos_y  = y;
    in_pos_z  = z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write a register once the pipeline has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] signed_span(input int bits);
    logic [31:0] v;
    v = $urandom_range((1 << bits) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random point: mostly structured shapes that reach the axis branch, tiny radii that
  // saturate, and zero radius; the rest is full-width noise.
  task automatic send_random;
    logic [31:0] x, y, z;
    logic op;
    op = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: begin x = $urandom; y = $urandom; z = $urandom; end
      1: begin x = signed_span(20); y = signed_span(20); z = signed_span(20); end
      2: begin x = signed_span(4); y = signed_span(4); z = $urandom; end
      3: begin
        x = 0; y = 0; z = 0;
        case ($urandom_range(3))
          0: x = $urandom;
          1: y = $urandom;
          2: z = $urandom;
          default: ;
        endcase
      end
      4: begin x = signed_span(27); y = signed_span(27); z = signed_span(27); end
      default: begin x = signed_span(2); y = signed_span(2); z = signed_span(2); end
    endcase
    send_point(op, x, y, z);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random();
  endtask

  initial begin
    in_valid = 1'b0;
    in_opcode = OP_METRIC;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MASS;
    cfg_data = '0;
    out_ready = 1'b0;
    out_hold = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero radius, extremes, axis points and tiny radii under reset settings.
    for (int op = 0; op < 2; op++) begin
      send_point(1'(op), 32'h0, 32'h0, 32'h0);
      send_point(1'(op), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(1'(op), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(1'(op), 32'h0, 32'h0, 32'h0100_0000);
      send_point(1'(op), 32'h1, 32'h0, 32'hFF00_0000);
      send_point(1'(op), 32'h1, 32'h0, 32'h0);
      send_point(1'(op), 32'hFFFF_FFFF, 32'h1, 32'h0);
      send_point(1'(op), 32'h0300_0000, 32'hFC00_0000, 32'h0100_0000);
    end
    write_reg(REG_SPARE_A, DATA_MAX);
    write_reg(REG_SPARE_B, '0);
    send_point(OP_METRIC, 32'h0200_0000, 32'h0, 32'h0);
    send_point(OP_CURVATURE, 32'h0200_0000, 32'h0, 32'h0);

    // Phase 1: reset settings, sparse sender gaps, heavy receiver stalls.
    in_idle_pct = 17;
    out_idle_pct = 79;
    run_random(ITEMS_PER_PHASE);

    // Phase 2: random mass and tolerance, roles of the stalls swapped.
    write_reg(REG_MASS, CFG_DATA_W'($urandom));
    write_reg(REG_AXIS_TOL, CFG_DATA_W'($urandom_range(ONE_Q24)));
    in_idle_pct = 79;
    out_idle_pct = 17;
    run_random(ITEMS_PER_PHASE);

    // Phase 3: largest mass, tolerance of one, full rate plus one long output hold.
    write_reg(REG_MASS, DATA_MAX);
    write_reg(REG_AXIS_TOL, ONE_Q24);
    in_idle_pct = 0;
    out_idle_pct = 0;
    out_hold = 700;
    run_random(ITEMS_PER_PHASE);

    // Phase 4: zero mass, zero tolerance, then an over-wide tolerance write that masks.
    write_reg(REG_MASS, '0);
    write_reg(REG_AXIS_TOL, '0);
    run_random(ITEMS_PER_PHASE / 2);
    write_reg(REG_AXIS_TOL, DATA_MAX);
    run_random(ITEMS_PER_PHASE / 2);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
